// ===== rtl/ubc_pkg.sv =====
// Shared constants and types for the uniform border crop block.
package ubc_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_PIXEL_BITS = 8;

    // Width of the size registers and of the cropped size outputs.
    localparam int SIZE_W    = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0] RST_IMG_SIZE = SIZE_W'(64);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKGROUND = 2'd0,
        CFG_WIDTH      = 2'd1,
        CFG_HEIGHT     = 2'd2
    } t_cfg_idx;

endpackage

// ===== rtl/ubc_in_if.sv =====
// Input channel: one operation word with its pixel.
interface ubc_in_if #(parameter int PIX_W = 8);
    logic             valid;
    logic             ready;
    logic             op;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output op, output pixel_value, input ready);
    modport sink   (input valid, input op, input pixel_value, output ready);
endinterface

// ===== rtl/ubc_out_if.sv =====
// Result channel: one cropped pixel with the crop size and flags.
interface ubc_out_if #(parameter int PIX_W = 8);
    logic                      valid;
    logic                      ready;
    logic [PIX_W-1:0]          out_pixel;
    logic [ubc_pkg::SIZE_W-1:0] cropped_width;
    logic [ubc_pkg::SIZE_W-1:0] cropped_height;
    logic                      last_pixel;
    logic                      is_empty;

    modport source (output valid, output out_pixel, output cropped_width,
                    output cropped_height, output last_pixel, output is_empty,
                    input ready);
    modport sink   (input valid, input out_pixel, input cropped_width,
                    input cropped_height, input last_pixel, input is_empty,
                    output ready);
endinterface

// ===== rtl/ubc_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface ubc_cfg_if #(parameter int DATA_W = 8);
    logic                          valid;
    logic                          ready;
    logic [ubc_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/uniform_border_crop_core.sv =====
// Uniform border crop core: frame store, bounding box tracking and cropped readout.
//
// Usage: the input channel carries one word per operation. A word with op 0
// loads the next pixel of the frame in raster order; the pixel is written to
// the frame store and the bounding box of non-background pixels is updated.
// Once the last pixel of the frame (image_width by image_height) is loaded,
// each word with op 1 returns the next pixel of the cropped frame on the
// result channel, with the cropped size and a last-pixel mark; reading wraps
// around after the last pixel. A fetch on a frame that is all background returns a
// word with is_empty set and height 0. A fetch before the frame is complete
// returns nothing. A load on a complete frame starts a new frame.
// Throughput: loads are taken every cycle while no fetch is pending. A fetch
// reads the frame store, whose read port is registered; the data then passes
// to the output register, and the input is held off until the fetch has moved
// there, so a new fetch is not taken before the last one is through the store read.
// If the receiver stalls, the result waits in the output register and one
// more fetch may be accepted and parked; the input then stays stalled.
// Reset restores the register defaults and clears the box and pointers; the
// frame store itself is not cleared. Configuration words are taken at any
// time and should be written only while the block is idle.
module uniform_border_crop_core #(
    parameter int MAX_WIDTH  = ubc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ubc_pkg::DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = ubc_pkg::DEF_PIXEL_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ubc_in_if.sink    i_in,
    ubc_out_if.source o_out,
    ubc_cfg_if.sink   i_cfg
);
    import ubc_pkg::*;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W       = ((DIM_W + 1) > SIZE_W) ? (DIM_W + 1) : SIZE_W;

    localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(MAX_WIDTH);
    localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(MAX_HEIGHT - 1);

    // Configuration registers.
    logic [PIXEL_BITS-1:0] r_bg;
    logic [SIZE_W-1:0]     r_img_w;
    logic [SIZE_W-1:0]     r_img_h;

    // Frame and box state.
    logic [COL_W-1:0] r_load_col, n_load_col;
    logic [ROW_W-1:0] r_load_row, n_load_row;
    logic             r_complete, n_complete;
    logic             r_found, n_found;
    logic [ROW_W-1:0] r_min_row, n_min_row, r_max_row, n_max_row;
    logic [COL_W-1:0] r_min_col, n_min_col, r_max_col, n_max_col;
    logic [ROW_W-1:0] r_read_row, n_read_row;
    logic [COL_W-1:0] r_read_col, n_read_col;

    // Fetch waiting for its store read.
    logic              r_pend;
    logic [SIZE_W-1:0] r_pend_w, r_pend_h;
    logic              r_pend_last, r_pend_empty;

    // Output register.
    logic                  r_out_valid;
    logic [PIXEL_BITS-1:0] r_out_pixel;
    logic [SIZE_W-1:0]     r_out_w, r_out_h;
    logic                  r_out_last, r_out_empty;

    logic [PIXEL_BITS-1:0] r_store [STORE_DEPTH];
    logic [PIXEL_BITS-1:0] r_rdata;

    logic              in_acc, load_acc, fetch_acc, out_take;
    logic [SIZE_W-1:0] eff_w, eff_h;
    logic [SIZE_W-1:0] crop_w, crop_h;
    logic [COL_W-1:0]  b_col, b_min_col, b_max_col;
    logic [ROW_W-1:0]  b_row, b_min_row, b_max_row;
    logic              b_found, hit, col_wrap, row_wrap;
    logic [ADDR_W-1:0] wr_addr, rd_addr;

    assign in_acc    = i_in.valid && i_in.ready;
    assign load_acc  = in_acc && !i_in.op;
    assign fetch_acc = in_acc && i_in.op && r_complete;
    assign out_take  = r_pend && (!r_out_valid || o_out.ready);

    assign i_in.ready  = !r_pend;
    assign i_cfg.ready = 1'b1;

    // Size registers act as 1 when zero and as the maximum above it.
    always_comb begin
        if (r_img_w == '0) begin
            eff_w = SIZE_W'(1);
        end else if (CMP_W'(r_img_w) > CMP_W'(MAX_WIDTH)) begin
            eff_w = SIZE_W'(MAX_WIDTH);
        end else begin
            eff_w = r_img_w;
        end
        if (r_img_h == '0) begin
            eff_h = SIZE_W'(1);
        end else if (CMP_W'(r_img_h) > CMP_W'(MAX_HEIGHT)) begin
            eff_h = SIZE_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_img_h;
        end
    end

    assign crop_w = SIZE_W'({1'b0, r_max_col} - {1'b0, r_min_col} + 1'b1);
    assign crop_h = SIZE_W'({1'b0, r_max_row} - {1'b0, r_min_row} + 1'b1);

    // A load on a complete frame starts from the cleared state.
    always_comb begin
        if (r_complete) begin
            b_col     = '0;
            b_row     = '0;
            b_found   = 1'b0;
            b_min_row = ROW_LAST;
            b_max_row = '0;
            b_min_col = COL_LAST;
            b_max_col = '0;
        end else begin
            b_col     = r_load_col;
            b_row     = r_load_row;
            b_found   = r_found;
            b_min_row = r_min_row;
            b_max_row = r_max_row;
            b_min_col = r_min_col;
            b_max_col = r_max_col;
        end
    end

    assign hit      = (i_in.pixel_value != r_bg);
    assign col_wrap = (CMP_W'(b_col) + CMP_W'(1)) >= CMP_W'(eff_w);
    assign row_wrap = (CMP_W'(b_row) + CMP_W'(1)) >= CMP_W'(eff_h);
    assign wr_addr  = ADDR_W'(b_row) * ROW_STRIDE + ADDR_W'(b_col);
    assign rd_addr  = ADDR_W'(r_read_row) * ROW_STRIDE + ADDR_W'(r_read_col);

    always_comb begin
        n_load_col = r_load_col;
        n_load_row = r_load_row;
        n_complete = r_complete;
        n_found    = r_found;
        n_min_row  = r_min_row;
        n_max_row  = r_max_row;
        n_min_col  = r_min_col;
        n_max_col  = r_max_col;
        n_read_row = r_read_row;
        n_read_col = r_read_col;
        if (load_acc) begin
            n_complete = 1'b0;
            n_found    = b_found || hit;
            n_min_row  = (hit && b_row < b_min_row) ? b_row : b_min_row;
            n_max_row  = (hit && b_row > b_max_row) ? b_row : b_max_row;
            n_min_col  = (hit && b_col < b_min_col) ? b_col : b_min_col;
            n_max_col  = (hit && b_col > b_max_col) ? b_col : b_max_col;
            n_read_row = r_complete ? '0 : r_read_row;
            n_read_col = r_complete ? '0 : r_read_col;
            if (col_wrap) begin
                n_load_col = '0;
                if (row_wrap) begin
                    n_load_row = '0;
                    n_complete = 1'b1;
                    n_read_row = n_found ? n_min_row : '0;
                    n_read_col = n_found ? n_min_col : '0;
                end else begin
                    n_load_row = ROW_W'(b_row + 1'b1);
                end
            end else begin
                n_load_row = b_row;
                n_load_col = COL_W'(b_col + 1'b1);
            end
        end else if (fetch_acc && r_found) begin
            if (r_read_col >= r_max_col) begin
                n_read_col = r_min_col;
                if (r_read_row >= r_max_row) begin
                    n_read_row = r_min_row;
                end else begin
                    n_read_row = ROW_W'(r_read_row + 1'b1);
                end
            end else begin
                n_read_col = COL_W'(r_read_col + 1'b1);
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg        <= '0;
            r_img_w     <= RST_IMG_SIZE;
            r_img_h     <= RST_IMG_SIZE;
            r_load_col  <= '0;
            r_load_row  <= '0;
            r_complete  <= 1'b0;
            r_found     <= 1'b0;
            r_min_row   <= ROW_LAST;
            r_max_row   <= '0;
            r_min_col   <= COL_LAST;
            r_max_col   <= '0;
            r_read_row  <= '0;
            r_read_col  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_BACKGROUND: r_bg    <= i_cfg.data[PIXEL_BITS-1:0];
                    CFG_WIDTH:      r_img_w <= i_cfg.data[SIZE_W-1:0];
                    CFG_HEIGHT:     r_img_h <= i_cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            r_load_col <= n_load_col;
            r_load_row <= n_load_row;
            r_complete <= n_complete;
            r_found    <= n_found;
            r_min_row  <= n_min_row;
            r_max_row  <= n_max_row;
            r_min_col  <= n_min_col;
            r_max_col  <= n_max_col;
            r_read_row <= n_read_row;
            r_read_col <= n_read_col;
            if (fetch_acc) begin
                r_pend <= 1'b1;
            end else if (out_take) begin
                r_pend <= 1'b0;
            end
            if (out_take) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame store. Only one word is taken per cycle, so a fetch always reads
    // after the write of any earlier load has landed.
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_store[wr_addr] <= i_in.pixel_value;
        end
        if (fetch_acc) begin
            r_rdata <= r_store[rd_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (fetch_acc) begin
            if (r_found) begin
                r_pend_w     <= crop_w;
                r_pend_h     <= crop_h;
                r_pend_last  <= (r_read_row == r_max_row) && (r_read_col == r_max_col);
                r_pend_empty <= 1'b0;
            end else begin
                r_pend_w     <= eff_w;
                r_pend_h     <= '0;
                r_pend_last  <= 1'b1;
                r_pend_empty <= 1'b1;
            end
        end
        if (out_take) begin
            r_out_pixel <= r_pend_empty ? '0 : r_rdata;
            r_out_w     <= r_pend_w;
            r_out_h     <= r_pend_h;
            r_out_last  <= r_pend_last;
            r_out_empty <= r_pend_empty;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_pixel      = r_out_pixel;
    assign o_out.cropped_width  = r_out_w;
    assign o_out.cropped_height = r_out_h;
    assign o_out.last_pixel     = r_out_last;
    assign o_out.is_empty       = r_out_empty;

endmodule

// ===== rtl/ubc_checker.sv =====
// Port-level checks for the uniform border crop core, bound to the core module.
module ubc_checker #(
    parameter int PIXEL_BITS = ubc_pkg::DEF_PIXEL_BITS
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_in_op,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [PIXEL_BITS-1:0]      i_out_pixel,
    input logic [ubc_pkg::SIZE_W-1:0] i_out_width,
    input logic [ubc_pkg::SIZE_W-1:0] i_out_height,
    input logic                       i_out_last,
    input logic                       i_out_empty
);
    import ubc_pkg::*;

    // A stalled result word stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pixel)
            && $stable(i_out_width) && $stable(i_out_height)
            && $stable(i_out_last) && $stable(i_out_empty))
        else $error("result word changed while stalled");

    // A fresh result follows the acceptance of its fetch, passing first through
    // the store read and then through the output register.
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready && i_in_op, 2))
        else $error("result without a fetch two cycles earlier");

    // Loads never hold off the next word.
    a_load_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_op |=> i_in_ready)
        else $error("input stalled after a load");

    // An empty frame reports zero height, a zero pixel and the last mark.
    a_empty_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_empty |-> i_out_height == '0 && i_out_last
            && i_out_pixel == '0)
        else $error("malformed empty-frame result");

endmodule

bind uniform_border_crop_core ubc_checker #(.PIXEL_BITS(PIXEL_BITS)) u_ubc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_op      (i_in.op),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_pixel  (o_out.out_pixel),
    .i_out_width  (o_out.cropped_width),
    .i_out_height (o_out.cropped_height),
    .i_out_last   (o_out.last_pixel),
    .i_out_empty  (o_out.is_empty)
);
